// File: design/sir_pkg.sv
// shared types and constants of the sparse index reshape unit
`default_nettype none
package sir_pkg;

    localparam int DIM_W        = 16;
    localparam int NUM_DIMS     = 3;
    localparam int RANK_W       = 2;
    localparam int QUEUE_DEPTH  = 2;
    localparam int DEF_MAX_RANK = 3;
    localparam int DEF_DIM_BITS = 16;

    typedef logic [DIM_W-1:0] sir_dim_t;

    typedef enum logic [2:0] {
        REG_IN_RANK  = 3'd0,
        REG_OUT_RANK = 3'd1,
        REG_IN_DIM0  = 3'd2,
        REG_IN_DIM1  = 3'd3,
        REG_IN_DIM2  = 3'd4,
        REG_OUT_DIM0 = 3'd5,
        REG_OUT_DIM1 = 3'd6,
        REG_OUT_DIM2 = 3'd7
    } sir_reg_e;

    // effective shape: ranks clamped, dimensions beyond the rank read as 1
    typedef struct packed {
        logic [RANK_W-1:0]             in_rank;
        logic [RANK_W-1:0]             out_rank;
        logic [NUM_DIMS-1:0][DIM_W-1:0] in_dim;
        logic [NUM_DIMS-1:0][DIM_W-1:0] out_dim;
    } sir_cfg_t;

    // classified entry: used coordinates, coordinate range flag, frame end
    typedef struct packed {
        logic [NUM_DIMS-1:0][DIM_W-1:0] coord;
        logic                           err;
        logic                           last;
    } sir_item_t;

endpackage
`default_nettype wire

// File: design/sir_front.sv
// front end: takes input beats, masks coordinates and checks them against the shape
`default_nettype none
module sir_front #(
    parameter int DIM_BITS = sir_pkg::DEF_DIM_BITS
) (
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [47:0]          s_tdata,
    input  wire logic                 s_tlast,
    input  wire sir_pkg::sir_cfg_t    cfg,
    input  wire logic                 q_full,
    output logic                      q_push,
    output sir_pkg::sir_item_t        q_item
);
    import sir_pkg::*;

    localparam logic [DIM_W-1:0] CMASK = (DIM_BITS >= DIM_W) ? {DIM_W{1'b1}} :
                                         DIM_W'((32'd1 << DIM_BITS) - 32'd1);

    logic [DIM_W-1:0] raw;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item      = '0;
        q_item.last = s_tlast;
        raw         = '0;
        for (int j = 0; j < NUM_DIMS; j++) begin
            raw = s_tdata[j*DIM_W +: DIM_W] & CMASK;
            // unused dimensions carry coordinate 0 against a size of 1
            q_item.coord[j] = (RANK_W'(j) < cfg.in_rank) ? raw : '0;
            if (q_item.coord[j] >= cfg.in_dim[j]) begin
                q_item.err = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: design/sir_fifo.sv
// short queue between the front end and the arithmetic pipeline
`default_nettype none
module sir_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire sir_pkg::sir_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    not_empty,
    output sir_pkg::sir_item_t      pop_item
);
    import sir_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    sir_item_t       mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// File: design/sir_back.sv
// back end: linear position, size check and two restoring division pipelines
`default_nettype none
module sir_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire sir_pkg::sir_cfg_t  cfg,
    input  wire logic               item_valid,
    input  wire sir_pkg::sir_item_t item,
    output logic                    item_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [47:0]             m_tdata,
    output logic [0:0]              m_tuser,
    output logic                    m_tlast
);
    import sir_pkg::*;

    localparam int QB = DIM_W;          // quotient bits per division
    localparam int PW = 3 * DIM_W;      // position width
    localparam int SW = 2 * DIM_W;      // width of a two-dimension product

    logic adv;

    // shape products, registered: s12_reg from the output sizes, then size_reg from s12_reg
    logic [SW-1:0] s12_reg;
    logic [PW-1:0] size_reg;

    // multiply stages
    logic          v1_reg, v2_reg;
    logic [SW-1:0] p01_reg, u1_reg, u2_reg;
    logic [PW-1:0] t2_reg;
    logic          e1_reg, e2_reg, l1_reg, l2_reg;
    logic [PW-1:0] pos_sum;

    // division by the stride of new dimension 0, entry 0 is the position stage
    logic          va_reg [QB+1];
    logic          ea_reg [QB+1];
    logic          la_reg [QB+1];
    logic [PW-1:0] ra_reg [QB+1];
    logic [QB-1:0] qa_reg [QB+1];
    logic [PW-1:0] dva    [QB];
    logic          gea    [QB];

    // division by the stride of new dimension 1
    logic          vb_reg [QB];
    logic          eb_reg [QB];
    logic          lb_reg [QB];
    logic [SW-1:0] rb_reg [QB];
    logic [QB-1:0] qb_reg [QB];
    logic [QB-1:0] qc_reg [QB];
    logic [SW-1:0] rb_cur [QB];
    logic [QB-1:0] qb_cur [QB];
    logic [SW-1:0] dvb    [QB];
    logic          geb    [QB];

    logic          m_tvalid_reg;
    logic [47:0]   m_tdata_reg;
    logic          m_tuser_reg, m_tlast_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign item_pop = adv && item_valid;

    always_ff @(posedge aclk) begin
        s12_reg  <= {{DIM_W{1'b0}}, cfg.out_dim[1]} * {{DIM_W{1'b0}}, cfg.out_dim[2]};
        size_reg <= {{SW{1'b0}}, cfg.out_dim[0]} * {{DIM_W{1'b0}}, s12_reg};
    end

    assign pos_sum = t2_reg + {{DIM_W{1'b0}}, u2_reg};

    always_comb begin
        for (int i = 0; i < QB; i++) begin
            dva[i] = {{DIM_W{1'b0}}, s12_reg} << (QB - 1 - i);
            gea[i] = (ra_reg[i] >= dva[i]);
            rb_cur[i] = (i == 0) ? ra_reg[QB][SW-1:0] : rb_reg[(i == 0) ? 0 : i - 1];
            qb_cur[i] = (i == 0) ? '0 : qb_reg[(i == 0) ? 0 : i - 1];
            dvb[i] = {{DIM_W{1'b0}}, cfg.out_dim[2]} << (QB - 1 - i);
            geb[i] = (rb_cur[i] >= dvb[i]);
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i <= QB; i++) va_reg[i] <= 1'b0;
            for (int i = 0; i < QB; i++)  vb_reg[i] <= 1'b0;
        end else if (adv) begin
            v1_reg    <= item_valid;
            v2_reg    <= v1_reg;
            va_reg[0] <= v2_reg;
            for (int i = 0; i < QB; i++) va_reg[i+1] <= va_reg[i];
            vb_reg[0] <= va_reg[QB];
            for (int i = 1; i < QB; i++) vb_reg[i] <= vb_reg[i-1];
            m_tvalid_reg <= vb_reg[QB-1];
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            p01_reg <= {{DIM_W{1'b0}}, item.coord[0]} * {{DIM_W{1'b0}}, cfg.in_dim[1]};
            u1_reg  <= {{DIM_W{1'b0}}, item.coord[1]} * {{DIM_W{1'b0}}, cfg.in_dim[2]}
                       + {{DIM_W{1'b0}}, item.coord[2]};
            e1_reg  <= item.err;
            l1_reg  <= item.last;

            t2_reg  <= {{DIM_W{1'b0}}, p01_reg} * {{SW{1'b0}}, cfg.in_dim[2]};
            u2_reg  <= u1_reg;
            e2_reg  <= e1_reg;
            l2_reg  <= l1_reg;

            // a coordinate error may wrap the position; the result is zeroed anyway
            ra_reg[0] <= pos_sum;
            qa_reg[0] <= '0;
            ea_reg[0] <= e2_reg || (pos_sum >= size_reg);
            la_reg[0] <= l2_reg;
            for (int i = 0; i < QB; i++) begin
                ra_reg[i+1] <= gea[i] ? ra_reg[i] - dva[i] : ra_reg[i];
                qa_reg[i+1] <= {qa_reg[i][QB-2:0], gea[i]};
                ea_reg[i+1] <= ea_reg[i];
                la_reg[i+1] <= la_reg[i];
            end

            for (int i = 0; i < QB; i++) begin
                rb_reg[i] <= geb[i] ? rb_cur[i] - dvb[i] : rb_cur[i];
                qb_reg[i] <= {qb_cur[i][QB-2:0], geb[i]};
            end
            qc_reg[0] <= qa_reg[QB];
            eb_reg[0] <= ea_reg[QB];
            lb_reg[0] <= la_reg[QB];
            for (int i = 1; i < QB; i++) begin
                qc_reg[i] <= qc_reg[i-1];
                eb_reg[i] <= eb_reg[i-1];
                lb_reg[i] <= lb_reg[i-1];
            end

            m_tdata_reg <= eb_reg[QB-1] ? '0 :
                           {rb_reg[QB-1][DIM_W-1:0], qb_reg[QB-1], qc_reg[QB-1]};
            m_tuser_reg <= eb_reg[QB-1];
            m_tlast_reg <= lb_reg[QB-1];
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

endmodule
`default_nettype wire

// File: design/sparse_index_reshape_unit.sv
// top level of the sparse index reshape unit: shape registers, front end, queue, back end
//
//  channel | dir | handshake           | payload
//  s_      | in  | s_tvalid / s_tready | tdata coord0..2, tlast last_in
//  m_      | out | m_tvalid / m_tready | tdata new_coord0..2, tuser range_error, tlast last_out
//  cfg_    | in  | cfg_we              | cfg_addr register index, cfg_wdata value
//
// one beat per cycle in and out while the output is not stalled; the depth from input beat to result beat is
// set by the two 16-stage restoring dividers (one quotient bit per stage)
// reset clears the shape registers to rank 1 and all sizes 1, and empties the pipeline
// a stalled output holds the whole arithmetic pipeline; the two-entry queue then fills
// and s_tready drops
// derived shape products are registered after a register write, the stride product first and the size from it
`default_nettype none
module sparse_index_reshape_unit #(
    parameter int MAX_RANK = sir_pkg::DEF_MAX_RANK,
    parameter int DIM_BITS = sir_pkg::DEF_DIM_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // coord0 [15:0], coord1 [31:16], coord2 [47:32]
    input  wire logic        s_tlast,   // last_in
    // result beats
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // new_coord0 [15:0], new_coord1 [31:16], new_coord2 [47:32]
    output logic [0:0]       m_tuser,   // range_error [0]
    output logic             m_tlast,   // last_out
    // register writes
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);
    import sir_pkg::*;

    // shape registers as written
    logic [RANK_W-1:0] in_rank_reg, out_rank_reg;
    sir_dim_t          in_dim_reg  [NUM_DIMS];
    sir_dim_t          out_dim_reg [NUM_DIMS];

    // effective shape seen by the datapath
    sir_cfg_t          cfg;
    logic [RANK_W-1:0] in_rank_eff, out_rank_eff;

    // queue hookup
    logic              q_full, q_push, q_pop, q_not_empty;
    sir_item_t         q_push_item, q_pop_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_rank_reg  <= RANK_W'(1);
            out_rank_reg <= RANK_W'(1);
            for (int j = 0; j < NUM_DIMS; j++) begin
                in_dim_reg[j]  <= sir_dim_t'(1);
                out_dim_reg[j] <= sir_dim_t'(1);
            end
        end else if (cfg_we) begin
            unique case (sir_reg_e'(cfg_addr))
                REG_IN_RANK:  in_rank_reg    <= cfg_wdata[RANK_W-1:0];
                REG_OUT_RANK: out_rank_reg   <= cfg_wdata[RANK_W-1:0];
                REG_IN_DIM0:  in_dim_reg[0]  <= cfg_wdata;
                REG_IN_DIM1:  in_dim_reg[1]  <= cfg_wdata;
                REG_IN_DIM2:  in_dim_reg[2]  <= cfg_wdata;
                REG_OUT_DIM0: out_dim_reg[0] <= cfg_wdata;
                REG_OUT_DIM1: out_dim_reg[1] <= cfg_wdata;
                REG_OUT_DIM2: out_dim_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // rank 0 acts as 1, ranks above the maximum clamp to it
    always_comb begin
        in_rank_eff  = (in_rank_reg == '0) ? RANK_W'(1) :
                       (in_rank_reg > RANK_W'(MAX_RANK)) ? RANK_W'(MAX_RANK) : in_rank_reg;
        out_rank_eff = (out_rank_reg == '0) ? RANK_W'(1) :
                       (out_rank_reg > RANK_W'(MAX_RANK)) ? RANK_W'(MAX_RANK) : out_rank_reg;
        cfg.in_rank  = in_rank_eff;
        cfg.out_rank = out_rank_eff;
        for (int j = 0; j < NUM_DIMS; j++) begin
            cfg.in_dim[j]  = (RANK_W'(j) < in_rank_eff)  ? in_dim_reg[j]  : sir_dim_t'(1);
            cfg.out_dim[j] = (RANK_W'(j) < out_rank_eff) ? out_dim_reg[j] : sir_dim_t'(1);
        end
    end

    sir_front #(
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cfg      (cfg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_push_item)
    );

    sir_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_pop_item)
    );

    sir_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (q_not_empty),
        .item       (q_pop_item),
        .item_pop   (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // a flagged result never carries coordinates
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("range error beat with nonzero coordinates");

    // new_coord2 stays zero while the new rank is below 3
    a_rank_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_rank_eff != RANK_W'(3)) |-> m_tdata[47:32] == '0)
        else $error("new_coord2 set beyond the new rank");

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result beat straight after reset");

endmodule
`default_nettype wire
